/* hw/rtl/sip_pkg.sv */
// Shared types, constants and helper functions of the sample interpolator.
`timescale 1ns / 1ps

package sip_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_SAMPLE_RATE  = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam int RATE_W  = 18;
  localparam int COUNT_W = 17;
  localparam int LEN_W   = 21;
  localparam int FRAC_W  = 24;
  localparam int POS_W   = 50;
  localparam int INT_W   = 26;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd65536;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [1:0] {
    MODE_COS,
    MODE_TRUNC,
    MODE_CUBIC
  } sip_mode_t;

  typedef struct packed {
    sip_mode_t   mode;
    logic [23:0] frac;
    logic [15:0] mu;
    logic [1:0]  rot;
  } sip_meta_t;

  // Raised-cosine weight in UQ1.15 for table entry k of 2^bits + 1.
  function automatic logic [15:0] cos_weight(int unsigned k_in, int unsigned bits);
    logic [63:0]        full;
    logic [63:0]        half;
    logic [63:0]        k;
    logic [63:0]        x;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic [63:0]        w;
    logic               mirror;
    int                 n;
    full = 64'd1 << bits;
    half = full >> 1;
    k = 64'(k_in);
    if (k > full) begin
      k = full;
    end
    mirror = (k > half);
    if (mirror) begin
      k = full - k;
    end
    x = (PI_Q30 * k) >> bits;
    mag = ONE_Q30;
    sum = $signed(ONE_Q30);
    for (n = 1; n <= 10; n++) begin
      mag = (mag * x) >> 30;
      mag = (mag * x) >> 30;
      mag = mag / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    w = (ONE_Q30 - 64'(sum) + 64'd32768) >> 16;
    if (mirror) begin
      w = 64'd32768 - w;
    end
    return w[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -50'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sip_bank.sv */
// One bank of the sample memory with a registered read port.
`timescale 1ns / 1ps

module sip_bank #(
  parameter int ROWS = 32768,
  parameter int AW   = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [ROWS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sip_front.sv */
// Input register, position product and query decode with the cosine table.
`timescale 1ns / 1ps

module sip_front #(
  parameter int DEPTH          = 65536,
  parameter int COS_TABLE_BITS = 8,
  parameter int IDX_W          = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic                           channel,
  input  logic [15:0]                    sample_index,
  input  logic [15:0]                    sample_value,
  input  logic [31:0]                    time_point,
  input  logic [sip_pkg::RATE_W-1:0]     sample_rate,
  input  logic [sip_pkg::COUNT_W-1:0]    sample_count,
  input  logic                           dn_ready,
  output logic                           q_valid,
  output sip_pkg::sip_meta_t             meta,
  output logic [IDX_W-1:0]               start,
  output logic                           ch,
  output logic                           wr_valid,
  output logic [IDX_W-1:0]               widx,
  output logic [15:0]                    wval
);

  localparam int TBL  = (1 << COS_TABLE_BITS) + 1;
  localparam int DROP = sip_pkg::FRAC_W - COS_TABLE_BITS;
  localparam int KW   = COS_TABLE_BITS + 1;

  logic [15:0] cos_lut [TBL];

  for (genvar k = 0; k < TBL; k++) begin : g_lut
    assign cos_lut[k] = sip_pkg::cos_weight(k, COS_TABLE_BITS);
  end

  logic v0_r, v1_r, q2_r, w2_r;
  logic en0, en1, en2;

  logic        cmd0_r, ch0_r;
  logic [15:0] idx0_r, val0_r;
  logic [31:0] tm0_r;

  logic                         cmd1_r, ch1_r;
  logic [15:0]                  idx1_r, val1_r;
  logic [sip_pkg::POS_W-1:0]    pos1_r;
  logic [sip_pkg::LEN_W-1:0]    len1_r;
  logic [sip_pkg::LEN_W-1:0]    len1_nxt;

  sip_pkg::sip_meta_t meta2_r, meta2_nxt;
  logic [IDX_W-1:0]   start2_r, start2_nxt;
  logic               ch2_r;
  logic [IDX_W-1:0]   widx2_r;
  logic [15:0]        wval2_r;
  logic               w2_nxt;

  logic [sip_pkg::INT_W:0]  i27;
  logic [sip_pkg::INT_W:0]  len27;
  logic [sip_pkg::INT_W:0]  s27;
  logic [24:0]              fr;
  logic [KW-1:0]            kidx;
  logic [sip_pkg::LEN_W-1:0] cnt21;

  assign en2      = !(q2_r || w2_r) || dn_ready;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      q2_r <= 1'b0;
      w2_r <= 1'b0;
    end else begin
      if (en0) begin
        v0_r <= in_valid;
      end
      if (en1) begin
        v1_r <= v0_r;
      end
      if (en2) begin
        q2_r <= v1_r && (cmd1_r == sip_pkg::CMD_QUERY);
        w2_r <= w2_nxt;
      end
    end
  end

  always_comb begin
    cnt21 = sip_pkg::LEN_W'(sample_count);
    if (cnt21 < 21'd2) begin
      len1_nxt = 21'd2;
    end else if (cnt21 > sip_pkg::LEN_W'(DEPTH)) begin
      len1_nxt = sip_pkg::LEN_W'(DEPTH);
    end else begin
      len1_nxt = cnt21;
    end
  end

  always_comb begin
    i27   = {1'b0, pos1_r[sip_pkg::POS_W-1:sip_pkg::FRAC_W]};
    len27 = (sip_pkg::INT_W + 1)'(len1_r);
    meta2_nxt.frac = pos1_r[sip_pkg::FRAC_W-1:0];
    fr   = {1'b0, pos1_r[sip_pkg::FRAC_W-1:0]} + 25'(1 << (DROP - 1));
    kidx = fr[24:DROP];
    meta2_nxt.mu = cos_lut[kidx];
    priority if (i27 == '0) begin
      meta2_nxt.mode = sip_pkg::MODE_COS;
      s27 = '0;
    end else if (i27 >= len27 - 27'd1) begin
      meta2_nxt.mode = sip_pkg::MODE_TRUNC;
      s27 = len27 - 27'd1;
    end else if (i27 + 27'd3 >= len27) begin
      meta2_nxt.mode = sip_pkg::MODE_COS;
      s27 = i27;
    end else begin
      meta2_nxt.mode = sip_pkg::MODE_CUBIC;
      s27 = i27 - 27'd1;
    end
    start2_nxt    = IDX_W'(s27);
    meta2_nxt.rot = s27[1:0];
    w2_nxt = v1_r && (cmd1_r == sip_pkg::CMD_LOAD) && (32'(idx1_r) < 32'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      cmd0_r <= command;
      ch0_r  <= channel;
      idx0_r <= sample_index;
      val0_r <= sample_value;
      tm0_r  <= time_point;
    end
    if (en1) begin
      cmd1_r <= cmd0_r;
      ch1_r  <= ch0_r;
      idx1_r <= idx0_r;
      val1_r <= val0_r;
      pos1_r <= tm0_r * sample_rate;
      len1_r <= len1_nxt;
    end
    if (en2) begin
      meta2_r  <= meta2_nxt;
      start2_r <= start2_nxt;
      ch2_r    <= ch1_r;
      widx2_r  <= IDX_W'(idx1_r);
      wval2_r  <= val1_r;
    end
  end

  assign q_valid  = q2_r;
  assign meta     = meta2_r;
  assign start    = start2_r;
  assign ch       = ch2_r;
  assign wr_valid = w2_r;
  assign widx     = widx2_r;
  assign wval     = wval2_r;

endmodule

/* hw/rtl/sip_interp.sv */
// Cosine, truncation and Catmull-Rom arithmetic pipeline with the output register.
`timescale 1ns / 1ps

module sip_interp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sip_pkg::sip_meta_t meta,
  input  logic [3:0][15:0]   rd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_value
);

  logic v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic en3, en4, en5, en6, en7, en8;

  sip_pkg::sip_meta_t m3_r;

  logic signed [15:0] yj [4];
  logic signed [18:0] dy, c3;
  logic signed [19:0] c2;
  logic signed [16:0] dd;
  logic signed [24:0] fs4;
  logic [16:0]        wa_u;
  logic signed [17:0] wa, wb;

  logic signed [43:0] p4_r;
  logic signed [19:0] c2_4_r;
  logic signed [16:0] d4_r;
  logic signed [15:0] y1_4_r, yt4_r;
  logic signed [33:0] cp1_4_r, cp2_4_r;
  logic [23:0]        f4_r;
  sip_pkg::sip_mode_t mode4_r;

  logic signed [19:0] ph;
  logic signed [24:0] fs5;
  logic [47:0]        q2;
  logic signed [44:0] q1_5_nxt, c2f_5_nxt;
  logic signed [44:0] q1_5_r, c2f_5_r;
  logic [23:0]        q2h_5_r;
  logic signed [16:0] d5_r;
  logic signed [15:0] y1_5_r, yt5_r;
  logic signed [34:0] cacc5_r;
  logic [23:0]        f5_r;
  sip_pkg::sip_mode_t mode5_r;

  logic signed [47:0] s1_nxt;
  logic signed [49:0] cr;
  logic signed [15:0] pre6_nxt;
  logic signed [47:0] s1_6_r;
  logic signed [15:0] y1_6_r, pre6_r;
  logic [23:0]        f6_r;
  sip_pkg::sip_mode_t mode6_r;

  logic signed [23:0] s1h;
  logic signed [24:0] fs7;
  logic [47:0]        r2f;
  logic signed [48:0] r1_nxt;
  logic signed [48:0] r1_7_r;
  logic [23:0]        r2h_7_r;
  logic signed [15:0] y1_7_r, pre7_r;
  sip_pkg::sip_mode_t mode7_r;

  logic signed [49:0] total, rounded;
  logic signed [15:0] res_nxt;
  logic [15:0]        res8_r;

  assign en8      = !v8_r || out_ready;
  assign en7      = !v7_r || en8;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      yj[j] = $signed(rd[m3_r.rot + 2'(j)]);
    end
    dy   = 19'(yj[1]) - 19'(yj[2]);
    c3   = (dy <<< 1) + dy + 19'(yj[3]) - 19'(yj[0]);
    c2   = (20'(yj[0]) <<< 1) - ((20'(yj[1]) <<< 2) + 20'(yj[1]))
         + (20'(yj[2]) <<< 2) - 20'(yj[3]);
    dd   = 17'(yj[2]) - 17'(yj[0]);
    fs4  = $signed({1'b0, m3_r.frac});
    wa_u = 17'd32768 - 17'(m3_r.mu);
    wa   = $signed({1'b0, wa_u});
    wb   = $signed({2'b00, m3_r.mu});
  end

  always_comb begin
    ph        = p4_r[43:24];
    fs5       = $signed({1'b0, f4_r});
    q1_5_nxt  = ph * fs5;
    q2        = p4_r[23:0] * f4_r;
    c2f_5_nxt = c2_4_r * fs5;
  end

  always_comb begin
    s1_nxt = (48'(d5_r) <<< 24) + 48'(c2f_5_r) + 48'(q1_5_r) + $signed({24'd0, q2h_5_r});
    cr     = (50'(cacc5_r) + 50'sd16384) >>> 15;
    if (mode5_r == sip_pkg::MODE_COS) begin
      pre6_nxt = sip_pkg::sat16(cr);
    end else begin
      pre6_nxt = yt5_r;
    end
  end

  always_comb begin
    s1h    = s1_6_r[47:24];
    fs7    = $signed({1'b0, f6_r});
    r1_nxt = s1h * fs7;
    r2f    = s1_6_r[23:0] * f6_r;
  end

  always_comb begin
    total   = (50'(y1_7_r) <<< 25) + 50'(r1_7_r) + $signed({26'd0, r2h_7_r});
    rounded = (total + (50'sd1 <<< 24)) >>> 25;
    if (mode7_r == sip_pkg::MODE_CUBIC) begin
      res_nxt = sip_pkg::sat16(rounded);
    end else begin
      res_nxt = pre7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m3_r <= meta;
    end
    if (en4) begin
      p4_r    <= c3 * fs4;
      c2_4_r  <= c2;
      d4_r    <= dd;
      y1_4_r  <= yj[1];
      yt4_r   <= yj[0];
      cp1_4_r <= yj[0] * wa;
      cp2_4_r <= yj[1] * wb;
      f4_r    <= m3_r.frac;
      mode4_r <= m3_r.mode;
    end
    if (en5) begin
      q1_5_r  <= q1_5_nxt;
      c2f_5_r <= c2f_5_nxt;
      q2h_5_r <= q2[47:24];
      d5_r    <= d4_r;
      y1_5_r  <= y1_4_r;
      yt5_r   <= yt4_r;
      cacc5_r <= 35'(cp1_4_r) + 35'(cp2_4_r);
      f5_r    <= f4_r;
      mode5_r <= mode4_r;
    end
    if (en6) begin
      s1_6_r  <= s1_nxt;
      y1_6_r  <= y1_5_r;
      pre6_r  <= pre6_nxt;
      f6_r    <= f5_r;
      mode6_r <= mode5_r;
    end
    if (en7) begin
      r1_7_r  <= r1_nxt;
      r2h_7_r <= r2f[47:24];
      y1_7_r  <= y1_6_r;
      pre7_r  <= pre6_r;
      mode7_r <= mode6_r;
    end
    if (en8) begin
      res8_r <= res_nxt;
    end
  end

  assign out_valid = v8_r;
  assign out_value = res8_r;

endmodule

/* hw/rtl/sample_interpolator_core.sv */
// Top level of the sample interpolator: configuration, banked sample memory and pipeline.
`timescale 1ns / 1ps

// The input channel carries loads and queries. in_tuser[0] is the command: a load
// writes one Q1.15 sample of a channel at sample_index, a query asks for the
// interpolated value of a channel at time_point (UQ8.24 seconds). Loads give no
// result; every query gives one item on the output channel, in order.
// Each channel's samples are spread over four memory banks by the low two index
// bits, so the four neighbors of a Catmull-Rom query are read in parallel, one from each bank.
// One item is taken every clock while the output is taken. A query result
// is shown on out_tvalid after it passes the input register, position
// product, decode and table lookup, memory read, and five arithmetic
// stages of the shared cubic multiply chain with the output register last.
// The configuration port writes sample_rate (index 0) and sample_count
// (index 1); write it only while no item is in flight.
// Reset clears the pipeline valid bits and restores the register defaults
// (48000 and 65536); the sample memory is undefined until loaded.
// When out_tready is low the pipeline stalls stage by stage: empty stages
// keep filling, so a few more items are accepted before in_tready drops.
module sample_interpolator_core #(
  parameter int CHANNELS       = 2,
  parameter int DEPTH          = 65536,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [71:0]                 in_tdata,   // channel, sample_index, sample_value, time_point
  input  logic [0:0]                  in_tuser,   // command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // value
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [sip_pkg::RATE_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int IXW   = IDX_W + 1;
  localparam int ROWS  = (DEPTH + 3) / 4;
  localparam int BROWS = CHANNELS * ROWS;
  localparam int AW    = $clog2(BROWS);

  logic [sip_pkg::RATE_W-1:0]  rate_r;
  logic [sip_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= sip_pkg::RATE_RESET;
      count_r <= sip_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == sip_pkg::REG_SAMPLE_RATE) begin
        rate_r <= cfg_wdata;
      end else begin
        count_r <= cfg_wdata[sip_pkg::COUNT_W-1:0];
      end
    end
  end

  logic               q_valid, wr_valid, ch, ch_eff, be_ready;
  sip_pkg::sip_meta_t meta;
  logic [IDX_W-1:0]   start, widx;
  logic [15:0]        wval;
  logic [3:0][15:0]   rd;
  logic [AW-1:0]      chbase;

  sip_front #(
    .DEPTH          (DEPTH),
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .IDX_W          (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .command      (in_tuser[0]),
    .channel      (in_tdata[0]),
    .sample_index (in_tdata[16:1]),
    .sample_value (in_tdata[32:17]),
    .time_point   (in_tdata[64:33]),
    .sample_rate  (rate_r),
    .sample_count (count_r),
    .dn_ready     (be_ready),
    .q_valid      (q_valid),
    .meta         (meta),
    .start        (start),
    .ch           (ch),
    .wr_valid     (wr_valid),
    .widx         (widx),
    .wval         (wval)
  );

  assign ch_eff = (CHANNELS > 1) ? ch : 1'b0;
  assign chbase = ch_eff ? AW'(ROWS) : '0;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]    j;
    logic [IXW-1:0] ix;
    logic [IXW-1:0] ixw;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;

    always_comb begin
      j  = 2'(b) - start[1:0];
      ix = {1'b0, start} + IXW'(j);
      if (ix >= IXW'(DEPTH)) begin
        ixw = ix - IXW'(DEPTH);
      end else begin
        ixw = ix;
      end
      raddr = chbase + AW'(ixw[IDX_W-1:2]);
      waddr = chbase + AW'(widx[IDX_W-1:2]);
      we    = wr_valid && be_ready && (widx[1:0] == 2'(b));
    end

    sip_bank #(
      .ROWS (BROWS),
      .AW   (AW)
    ) u_bank (
      .clk   (clk),
      .en    (be_ready),
      .we    (we),
      .waddr (waddr),
      .wdata (wval),
      .raddr (raddr),
      .rdata (rd[b])
    );
  end

  sip_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (be_ready),
    .meta      (meta),
    .rd        (rd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata)
  );

endmodule
